[src/gcbd_pkg.sv]
package gcbd_pkg;

    // Geometry limits
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;
    localparam int unsigned MAX_RATIO  = 16;

    localparam int unsigned NUM_CHAN    = 4;
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned CHAN_LEVELS = 1 << CHAN_W;

    localparam int unsigned W_W    = $clog2(MAX_WIDTH + 1);    // width register
    localparam int unsigned H_W    = $clog2(MAX_HEIGHT + 1);   // height register
    localparam int unsigned R_W    = $clog2(MAX_RATIO + 1);    // ratio register
    localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);        // line store address
    localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
    localparam int unsigned RIB_W  = $clog2(MAX_RATIO);        // offset inside a block
    localparam int unsigned SUM_W  = $clog2(MAX_RATIO * MAX_RATIO * (CHAN_LEVELS - 1) + 1);

    // Config port
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [W_W-1:0] WIDTH_RESET  = W_W'(1024);
    localparam logic [H_W-1:0] HEIGHT_RESET = H_W'(1024);
    localparam logic [R_W-1:0] RATIO_RESET  = R_W'(2);

    // Register index (paddr[3:2]); the last slot holds no register.
    typedef enum logic [1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_RATIO,
        REG_SPARE
    } reg_idx_t;

    // Divide by ratio^2 as multiply by ceil(2^24 / ratio^2). Exact for sums
    // up to 65280 since sum * error < 2^24.
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
    localparam int unsigned RECIP_ONE   = 1 << RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_RATIO] = '{
        RECIP_W'((RECIP_ONE +   0) /   1),
        RECIP_W'((RECIP_ONE +   3) /   4),
        RECIP_W'((RECIP_ONE +   8) /   9),
        RECIP_W'((RECIP_ONE +  15) /  16),
        RECIP_W'((RECIP_ONE +  24) /  25),
        RECIP_W'((RECIP_ONE +  35) /  36),
        RECIP_W'((RECIP_ONE +  48) /  49),
        RECIP_W'((RECIP_ONE +  63) /  64),
        RECIP_W'((RECIP_ONE +  80) /  81),
        RECIP_W'((RECIP_ONE +  99) / 100),
        RECIP_W'((RECIP_ONE + 120) / 121),
        RECIP_W'((RECIP_ONE + 143) / 144),
        RECIP_W'((RECIP_ONE + 168) / 169),
        RECIP_W'((RECIP_ONE + 195) / 196),
        RECIP_W'((RECIP_ONE + 224) / 225),
        RECIP_W'((RECIP_ONE + 255) / 256)
    };

    typedef logic [CHAN_W-1:0]         chan_t;
    typedef chan_t [NUM_CHAN-1:0]      pixel_t;
    typedef logic [SUM_W-1:0]          sum_t;
    typedef sum_t [NUM_CHAN-1:0]       sum_vec_t;
    typedef logic [CHAN_W-1:0]         curve_t [CHAN_LEVELS];

    typedef struct packed {
        logic [W_W-1:0] width;
        logic [H_W-1:0] height;
        logic [R_W-1:0] ratio;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              keep;
        logic              first;
        logic              last;
        logic              frame_done;
    } pos_t;

    typedef struct packed {
        sum_vec_t sums;
        logic     frame_done;
    } acc_word_t;

    // Exact gamma curves: integer powers on both sides, no rounding error.
    function automatic logic [127:0] ipow(input logic [127:0] base, input int unsigned e);
        logic [127:0] acc;
        acc = 128'd1;
        for (int unsigned n = 0; n < e; n++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // v - 0.5 <= 255*(i/255)^2.2
    function automatic logic lin_ok(input int unsigned v, input int unsigned i);
        return (ipow(128'(2 * v - 1), 5) * ipow(128'd255, 6)) <= (128'd32 * ipow(128'(i), 11));
    endfunction

    // w - 0.5 <= 255*(i/255)^(1/2.2)
    function automatic logic gam_ok(input int unsigned w, input int unsigned i);
        return ipow(128'(2 * w - 1), 11) <= (128'd2048 * ipow(128'(i), 5) * ipow(128'd255, 6));
    endfunction

    function automatic curve_t build_lin_table();
        curve_t      t;
        int unsigned v;
        v = 0;
        for (int unsigned i = 0; i < CHAN_LEVELS; i++) begin
            while (v < CHAN_LEVELS - 1 && lin_ok(v + 1, i)) begin
                v++;
            end
            t[i] = CHAN_W'(v);
        end
        return t;
    endfunction

    function automatic curve_t build_gam_table();
        curve_t      t;
        int unsigned w;
        w = 0;
        for (int unsigned i = 0; i < CHAN_LEVELS; i++) begin
            while (w < CHAN_LEVELS - 1 && gam_ok(w + 1, i)) begin
                w++;
            end
            t[i] = CHAN_W'(w);
        end
        return t;
    endfunction

    localparam curve_t LIN_TABLE = build_lin_table();
    localparam curve_t GAM_TABLE = build_gam_table();

endpackage

[src/gamma_correct_box_downscale_unit.sv]
// Gamma-correct box downscaler for an RGBA pixel stream.
// Input words (s_valid/s_ready) carry one source pixel each, in raster order.
// Each channel is linearized through a gamma 2.2 table and summed per output
// column in a 1024 x 64-bit line store; on the last pixel of each
// ratio x ratio block the sums are divided by ratio^2 (reciprocal multiply),
// re-encoded and sent as one output word (m_valid/m_ready). m_frame_done
// marks the last output word of a frame. Partial blocks at the right and
// bottom edges are dropped.
// Throughput: one pixel per clock, set by the line store's read-modify-write
// (read at accept, write back as the pixel retires, with write-back forwarding).
// A closing block sum passes the block sum, quotient and output registers in turn.
// Receiver stall: the output register holds the word; pixels that close no
// block keep flowing, and input stalls only once a closing block sum cannot
// enter the divide pipe.
// Config (APB, width/height/ratio at 0x0/0x4/0x8) is written while idle;
// any such write restarts the frame position. Reset restores 1024 x 1024, ratio 2,
// and zeroes the position. The line store needs no clearing: the first pixel
// of each block overwrites its entry.
module gamma_correct_box_downscale_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gcbd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gcbd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gcbd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    // source pixels
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gcbd_pkg::CHAN_W-1:0]     s_in_red,
    input  logic [gcbd_pkg::CHAN_W-1:0]     s_in_green,
    input  logic [gcbd_pkg::CHAN_W-1:0]     s_in_blue,
    input  logic [gcbd_pkg::CHAN_W-1:0]     s_in_alpha,
    // downscaled pixels
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gcbd_pkg::CHAN_W-1:0]     m_out_red,
    output logic [gcbd_pkg::CHAN_W-1:0]     m_out_green,
    output logic [gcbd_pkg::CHAN_W-1:0]     m_out_blue,
    output logic [gcbd_pkg::CHAN_W-1:0]     m_out_alpha,
    output logic                            m_frame_done
);
    import gcbd_pkg::*;

    cfg_t      cfg;
    logic      restart;
    pos_t      pos;
    pixel_t    in_pixel;
    pixel_t    out_pixel;
    logic      sum_valid;
    logic      sum_ready;
    acc_word_t sum_word;

    assign pready = 1'b1;

    // channel order: red, green, blue, alpha
    assign in_pixel[0] = s_in_red;
    assign in_pixel[1] = s_in_green;
    assign in_pixel[2] = s_in_blue;
    assign in_pixel[3] = s_in_alpha;

    gcbd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .restart (restart)
    );

    // frame position: block column, offsets, keep/first/last flags
    gcbd_pos u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .restart (restart),
        .accept  (s_valid && s_ready),
        .pos     (pos)
    );

    // linearize and accumulate into the line store
    gcbd_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pixel  (in_pixel),
        .in_pos    (pos),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum_word  (sum_word)
    );

    // divide by ratio^2, re-encode, output register
    gcbd_norm u_norm (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ratio          (cfg.ratio),
        .sum_valid      (sum_valid),
        .sum_ready      (sum_ready),
        .sum_word       (sum_word),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_pixel      (out_pixel),
        .out_frame_done (m_frame_done)
    );

    assign m_out_red   = out_pixel[0];
    assign m_out_green = out_pixel[1];
    assign m_out_blue  = out_pixel[2];
    assign m_out_alpha = out_pixel[3];

endmodule

[src/gcbd_cfg.sv]
module gcbd_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gcbd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gcbd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gcbd_pkg::CFG_DATA_W-1:0] prdata,
    output gcbd_pkg::cfg_t                  cfg,
    output logic                            restart
);
    import gcbd_pkg::*;

    logic [W_W-1:0] width_reg;
    logic [H_W-1:0] height_reg;
    logic [R_W-1:0] ratio_reg;
    logic           wr_en;
    reg_idx_t       idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = reg_idx_t'(paddr[3:2]);

    always_comb begin
        prdata  = '0;
        restart = 1'b0;
        unique case (idx)
            REG_WIDTH: begin
                prdata  = CFG_DATA_W'(width_reg);
                restart = wr_en;
            end
            REG_HEIGHT: begin
                prdata  = CFG_DATA_W'(height_reg);
                restart = wr_en;
            end
            REG_RATIO: begin
                prdata  = CFG_DATA_W'(ratio_reg);
                restart = wr_en;
            end
            default: begin
                prdata  = '0;
                restart = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            ratio_reg  <= RATIO_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_WIDTH:  width_reg  <= pwdata[W_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[H_W-1:0];
                REG_RATIO:  ratio_reg  <= pwdata[R_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to the supported range
    always_comb begin
        cfg.width = (width_reg == '0) ? W_W'(1) :
                    (width_reg > W_W'(MAX_WIDTH)) ? W_W'(MAX_WIDTH) : width_reg;
        cfg.height = (height_reg == '0) ? H_W'(1) :
                     (height_reg > H_W'(MAX_HEIGHT)) ? H_W'(MAX_HEIGHT) : height_reg;
        cfg.ratio = (ratio_reg == '0) ? R_W'(1) :
                    (ratio_reg > R_W'(MAX_RATIO)) ? R_W'(MAX_RATIO) : ratio_reg;
    end

`ifndef ASSERT_OFF
    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.width != '0 && cfg.width <= W_W'(MAX_WIDTH))
        else $error("clamped width out of range");
    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.ratio != '0 && cfg.ratio <= R_W'(MAX_RATIO))
        else $error("clamped ratio out of range");
    a_restart_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |-> wr_en)
        else $error("restart without a register write");
`endif

endmodule

[src/gcbd_pos.sv]
module gcbd_pos (
    input  logic           aclk,
    input  logic           aresetn,
    input  gcbd_pkg::cfg_t cfg,
    input  logic           restart,
    input  logic           accept,
    output gcbd_pkg::pos_t pos
);
    import gcbd_pkg::*;

    logic [ADDR_W-1:0] col_reg, col_next;
    logic [RIB_W-1:0]  cib_reg, cib_next;
    logic [ADDR_W-1:0] blk_reg, blk_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [RIB_W-1:0]  rib_reg, rib_next;

    logic [W_W-1:0] col_base;
    logic [W_W:0]   col_end, col_end2;
    logic [H_W-1:0] row_base;
    logic [H_W:0]   row_end, row_end2;
    logic [W_W-1:0] col_inc;
    logic [H_W-1:0] row_inc;
    logic [R_W-1:0] cib_inc, rib_inc;
    logic [R_W-1:0] r_last;

    // block start and one-past-end, no division needed
    always_comb begin
        r_last   = cfg.ratio - R_W'(1);
        col_base = W_W'(col_reg) - W_W'(cib_reg);
        col_end  = (W_W+1)'(col_base) + (W_W+1)'(cfg.ratio);
        col_end2 = col_end + (W_W+1)'(cfg.ratio);
        row_base = H_W'(row_reg) - H_W'(rib_reg);
        row_end  = (H_W+1)'(row_base) + (H_W+1)'(cfg.ratio);
        row_end2 = row_end + (H_W+1)'(cfg.ratio);

        pos.addr  = blk_reg;
        pos.keep  = (col_end <= (W_W+1)'(cfg.width)) && (row_end <= (H_W+1)'(cfg.height));
        pos.first = (cib_reg == '0) && (rib_reg == '0);
        pos.last  = (cib_reg == r_last[RIB_W-1:0]) && (rib_reg == r_last[RIB_W-1:0]);
        // last whole block column and last whole block row
        pos.frame_done = (col_end2 > (W_W+1)'(cfg.width)) &&
                         (row_end2 > (H_W+1)'(cfg.height));
    end

    always_comb begin
        col_inc  = W_W'(col_reg) + W_W'(1);
        row_inc  = H_W'(row_reg) + H_W'(1);
        cib_inc  = R_W'(cib_reg) + R_W'(1);
        rib_inc  = R_W'(rib_reg) + R_W'(1);
        col_next = col_reg;
        cib_next = cib_reg;
        blk_next = blk_reg;
        row_next = row_reg;
        rib_next = rib_reg;
        if (restart) begin
            col_next = '0;
            cib_next = '0;
            blk_next = '0;
            row_next = '0;
            rib_next = '0;
        end else if (accept) begin
            if (col_inc >= cfg.width) begin
                col_next = '0;
                cib_next = '0;
                blk_next = '0;
                if (row_inc >= cfg.height) begin
                    row_next = '0;
                    rib_next = '0;
                end else begin
                    row_next = row_inc[ROW_W-1:0];
                    rib_next = (rib_inc >= cfg.ratio) ? '0 : rib_inc[RIB_W-1:0];
                end
            end else begin
                col_next = col_inc[ADDR_W-1:0];
                if (cib_inc >= cfg.ratio) begin
                    cib_next = '0;
                    blk_next = blk_reg + ADDR_W'(1);
                end else begin
                    cib_next = cib_inc[RIB_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            cib_reg <= '0;
            blk_reg <= '0;
            row_reg <= '0;
            rib_reg <= '0;
        end else begin
            col_reg <= col_next;
            cib_reg <= cib_next;
            blk_reg <= blk_next;
            row_reg <= row_next;
            rib_reg <= rib_next;
        end
    end

`ifndef ASSERT_OFF
    a_cib_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        R_W'(cib_reg) < cfg.ratio)
        else $error("column offset past block edge");
    a_rib_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        R_W'(rib_reg) < cfg.ratio)
        else $error("row offset past block edge");
    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        W_W'(col_reg) < cfg.width)
        else $error("column past row end");
`endif

endmodule

[src/gcbd_accum.sv]
module gcbd_accum (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  gcbd_pkg::pixel_t    in_pixel,
    input  gcbd_pkg::pos_t      in_pos,
    output logic                sum_valid,
    input  logic                sum_ready,
    output gcbd_pkg::acc_word_t sum_word
);
    import gcbd_pkg::*;

    sum_vec_t mem [MAX_WIDTH];
    sum_vec_t rd_reg;

    logic              a_valid_reg;
    pixel_t            a_lin_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic              a_first_reg;
    logic              a_last_reg;
    logic              a_fd_reg;

    logic              wb_valid_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    sum_vec_t          wb_data_reg;

    logic     in_accept;
    logic     a_go;
    pixel_t   lin;
    sum_vec_t old_sum;
    sum_vec_t new_sum;

    assign in_accept = in_valid && in_ready;
    // non-final pixels retire without waiting on the divider
    assign a_go      = a_valid_reg && (!a_last_reg || sum_ready);
    assign in_ready  = !a_valid_reg || a_go;

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            lin[c] = LIN_TABLE[in_pixel[c]];
        end
    end

    // read-before-write memory: last write-back is forwarded
    assign old_sum = (wb_valid_reg && wb_addr_reg == a_addr_reg) ? wb_data_reg : rd_reg;

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            new_sum[c] = a_first_reg ? SUM_W'(a_lin_reg[c])
                                     : old_sum[c] + SUM_W'(a_lin_reg[c]);
        end
    end

    assign sum_valid           = a_valid_reg && a_last_reg;
    assign sum_word.sums       = new_sum;
    assign sum_word.frame_done = a_fd_reg;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_reg <= mem[in_pos.addr];
        end
        if (a_go) begin
            mem[a_addr_reg] <= new_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            wb_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                a_valid_reg <= in_pos.keep;
            end else if (a_go) begin
                a_valid_reg <= 1'b0;
            end
            if (a_go) begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            a_lin_reg   <= lin;
            a_addr_reg  <= in_pos.addr;
            a_first_reg <= in_pos.first;
            a_last_reg  <= in_pos.last;
            a_fd_reg    <= in_pos.frame_done;
        end
        if (a_go) begin
            wb_addr_reg <= a_addr_reg;
            wb_data_reg <= new_sum;
        end
    end

`ifndef ASSERT_OFF
    a_stall_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> a_valid_reg && a_last_reg && !sum_ready)
        else $error("input stalled with no blocked block sum");
    a_writeback_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        a_go |=> wb_valid_reg && wb_addr_reg == $past(a_addr_reg))
        else $error("write-back register missed a store");
    a_stalled_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !a_go |=> a_valid_reg && $stable(a_addr_reg))
        else $error("stalled accumulate stage lost its pixel");
`endif

endmodule

[src/gcbd_norm.sv]
module gcbd_norm (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [gcbd_pkg::R_W-1:0]     ratio,
    input  logic                         sum_valid,
    output logic                         sum_ready,
    input  gcbd_pkg::acc_word_t          sum_word,
    output logic                         out_valid,
    input  logic                         out_ready,
    output gcbd_pkg::pixel_t             out_pixel,
    output logic                         out_frame_done
);
    import gcbd_pkg::*;

    localparam int unsigned PROD_W = SUM_W + RECIP_W;

    logic      b_valid_reg;
    acc_word_t b_word_reg;
    logic      q_valid_reg;
    pixel_t    q_reg;
    logic      q_fd_reg;
    logic      m_valid_reg;
    pixel_t    m_pixel_reg;
    logic      m_fd_reg;

    logic               out_free, q_free, b_free;
    logic [R_W-1:0]     r_idx;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod [NUM_CHAN];
    pixel_t             quot;
    pixel_t             gam;

    assign out_free  = !m_valid_reg || out_ready;
    assign q_free    = !q_valid_reg || out_free;
    assign b_free    = !b_valid_reg || q_free;
    assign sum_ready = b_free;

    assign r_idx = ratio - R_W'(1);
    assign recip = RECIP_TABLE[r_idx[RIB_W-1:0]];

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            prod[c] = PROD_W'(b_word_reg.sums[c]) * PROD_W'(recip);
            quot[c] = prod[c][RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
            gam[c]  = GAM_TABLE[q_reg[c]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (b_free) begin
                b_valid_reg <= sum_valid;
            end
            if (q_free) begin
                q_valid_reg <= b_valid_reg;
            end
            if (out_free) begin
                m_valid_reg <= q_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_free) begin
            b_word_reg <= sum_word;
        end
        if (q_free) begin
            q_reg    <= quot;
            q_fd_reg <= b_word_reg.frame_done;
        end
        if (out_free) begin
            m_pixel_reg <= gam;
            m_fd_reg    <= q_fd_reg;
        end
    end

    assign out_valid      = m_valid_reg;
    assign out_pixel      = m_pixel_reg;
    assign out_frame_done = m_fd_reg;

`ifndef ASSERT_OFF
    a_b_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && q_free |=> q_valid_reg)
        else $error("block sum dropped before divide");
    a_q_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid_reg && out_free |=> m_valid_reg)
        else $error("quotient dropped before output");
    a_q_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid_reg && !out_free |=> q_valid_reg && $stable(q_reg))
        else $error("stalled quotient changed");
`endif

endmodule

[test/gamma_correct_box_downscale_unit_tb.sv]
`timescale 1ns / 100ps

// Gamma-correct box downscaler bench.
// A self-contained predictor follows the pixel stream, accumulates linearized
// block sums per output column and queues one expected word per closed block;
// the monitor matches every output word against the oldest one in that queue.
module gamma_correct_box_downscale_unit_tb;
    import gcbd_pkg::*;

    // One downscaled output word.
    typedef struct packed {
        gcbd_pkg::chan_t red;
        gcbd_pkg::chan_t green;
        gcbd_pkg::chan_t blue;
        gcbd_pkg::chan_t alpha;
        logic            frame_done;
    } block_pixel_t;

    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned QUIET_CYCLES = 8;
    localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no word moving

    // Tracks frame position and block sums, and holds the averaged words that
    // the block still owes us.
    class box_average_tracker_t;
        logic [10:0]     width_reg;
        logic [10:0]     height_reg;
        logic [4:0]      ratio_reg;
        int unsigned     src_col, src_row, col_in_blk, row_in_blk;
        int unsigned     col_sums [gcbd_pkg::MAX_WIDTH][4];
        gcbd_pkg::chan_t lin_curve [256];
        gcbd_pkg::chan_t gam_curve [256];
        block_pixel_t    awaited_blocks [$];
        int unsigned     mismatches;

        function new();
            int unsigned v, g;
            v = 0;
            g = 0;
            // Exact rounding of 255*(i/255)^2.2 and its inverse, decided by
            // comparing integer powers of both sides.
            for (int unsigned i = 0; i < 256; i++) begin
                while (v < 255 && raise(2 * (v + 1) - 1, 5) * raise(255, 6)
                                  <= 128'd32 * raise(i, 11))
                    v++;
                while (g < 255 && raise(2 * (g + 1) - 1, 11)
                                  <= 128'd2048 * raise(i, 5) * raise(255, 6))
                    g++;
                lin_curve[i] = gcbd_pkg::chan_t'(v);
                gam_curve[i] = gcbd_pkg::chan_t'(g);
            end
            width_reg   = 11'(gcbd_pkg::MAX_WIDTH);
            height_reg  = 11'(gcbd_pkg::MAX_HEIGHT);
            ratio_reg   = 5'd2;
            mismatches  = 0;
            restart();
        endfunction

        function logic [127:0] raise(input logic [127:0] base, input int unsigned n);
            logic [127:0] acc;
            acc = 128'd1;
            repeat (n) acc = acc * base;
            return acc;
        endfunction

        function int unsigned bound(input int unsigned v, input int unsigned lo,
                                    input int unsigned hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void restart();
            src_col    = 0;
            src_row    = 0;
            col_in_blk = 0;
            row_in_blk = 0;
        endfunction

        function void write_reg(input reg_idx_t idx, input logic [31:0] word);
            case (idx)
                REG_WIDTH:  width_reg  = word[10:0];
                REG_HEIGHT: height_reg = word[10:0];
                REG_RATIO:  ratio_reg  = word[4:0];
                default:    return;
            endcase
            restart();
        endfunction

        function void take_source_pixel(input gcbd_pkg::chan_t red,
                                        input gcbd_pkg::chan_t green,
                                        input gcbd_pkg::chan_t blue,
                                        input gcbd_pkg::chan_t alpha);
            gcbd_pkg::chan_t src [4];
            gcbd_pkg::chan_t enc [4];
            int unsigned     w, h, r, out_cols, out_rows, oc;
            logic            opens, last_word;
            src = '{red, green, blue, alpha};
            w = bound(width_reg, 1, gcbd_pkg::MAX_WIDTH);
            h = bound(height_reg, 1, gcbd_pkg::MAX_HEIGHT);
            r = bound(ratio_reg, 1, gcbd_pkg::MAX_RATIO);
            out_cols = w / r;
            out_rows = h / r;
            if (src_col < out_cols * r && src_row < out_rows * r) begin
                oc    = src_col / r;
                opens = (row_in_blk == 0 && col_in_blk == 0);
                for (int ch = 0; ch < 4; ch++)
                    col_sums[oc][ch] = opens ? lin_curve[src[ch]]
                                             : col_sums[oc][ch] + lin_curve[src[ch]];
                if (row_in_blk == r - 1 && col_in_blk == r - 1) begin
                    for (int ch = 0; ch < 4; ch++)
                        enc[ch] = gam_curve[(col_sums[oc][ch] / (r * r)) & 8'hFF];
                    last_word = (oc == out_cols - 1 && src_row == out_rows * r - 1);
                    awaited_blocks.insert(awaited_blocks.size(),
                        block_pixel_t'{enc[0], enc[1], enc[2], enc[3], last_word});
                end
            end
            src_col++;
            col_in_blk = (col_in_blk + 1 >= r) ? 0 : col_in_blk + 1;
            if (src_col >= w) begin
                src_col    = 0;
                col_in_blk = 0;
                src_row++;
                row_in_blk = (row_in_blk + 1 >= r) ? 0 : row_in_blk + 1;
                if (src_row >= h) begin
                    src_row    = 0;
                    row_in_blk = 0;
                end
            end
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_output_pixel(input block_pixel_t got);
            block_pixel_t want;
            if (awaited_blocks.size() == 0) begin
                $error("unexpected output word: %0d %0d %0d %0d done=%0d",
                       got.red, got.green, got.blue, got.alpha, got.frame_done);
                mismatches++;
                return;
            end
            want = awaited_blocks.pop_front();
            compare_field("out_red",    want.red,        got.red);
            compare_field("out_green",  want.green,      got.green);
            compare_field("out_blue",   want.blue,       got.blue);
            compare_field("out_alpha",  want.alpha,      got.alpha);
            compare_field("frame_done", want.frame_done, got.frame_done);
        endfunction
    endclass

    // Clock and reset; every input starts at a known value.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [gcbd_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [gcbd_pkg::CFG_DATA_W-1:0] pwdata  = '0;
    logic [gcbd_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    logic            s_valid    = 1'b0;
    logic            s_ready;
    gcbd_pkg::chan_t s_in_red   = '0;
    gcbd_pkg::chan_t s_in_green = '0;
    gcbd_pkg::chan_t s_in_blue  = '0;
    gcbd_pkg::chan_t s_in_alpha = '0;

    logic            m_valid;
    logic            m_ready = 1'b0;
    gcbd_pkg::chan_t m_out_red;
    gcbd_pkg::chan_t m_out_green;
    gcbd_pkg::chan_t m_out_blue;
    gcbd_pkg::chan_t m_out_alpha;
    logic            m_frame_done;

    box_average_tracker_t tracker = new();

    // Idling knobs: sender throttle lives in the stimulus process, receiver
    // throttle is flipped per phase so some stretches run back to back.
    logic        tx_throttle = 1'b1;
    logic        rx_throttle = 1'b1;
    int unsigned rx_hold     = 0;
    int unsigned quiet_run   = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    gamma_correct_box_downscale_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_red     (s_in_red),
        .s_in_green   (s_in_green),
        .s_in_blue    (s_in_blue),
        .s_in_alpha   (s_in_alpha),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .m_out_alpha  (m_out_alpha),
        .m_frame_done (m_frame_done)
    );

    // Gap length: mostly none, some short, a few long.
    function automatic int unsigned pick_gap(input logic throttle);
        int unsigned roll;
        if (!throttle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: one ready cycle, then a random stall.
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            rx_hold <= pick_gap(rx_throttle);
        end
    end

    // Monitor. The input is taken first so that a same-edge result would
    // still find its expectation; both sides sample pre-edge values.
    // Watchdog counts edges on which no word moves on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.take_source_pixel(s_in_red, s_in_green, s_in_blue, s_in_alpha);
            if (m_valid && m_ready)
                tracker.match_output_pixel('{m_out_red, m_out_green, m_out_blue,
                                             m_out_alpha, m_frame_done});
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_run <= 0;
            else
                quiet_run <= quiet_run + 1;
            if (quiet_run >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Holds valid until the word is taken; valid only drops for a gap.
    task automatic send_pixel(input gcbd_pkg::chan_t red, input gcbd_pkg::chan_t green,
                              input gcbd_pkg::chan_t blue, input gcbd_pkg::chan_t alpha);
        int unsigned gap;
        s_valid    <= 1'b1;
        s_in_red   <= red;
        s_in_green <= green;
        s_in_blue  <= blue;
        s_in_alpha <= alpha;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        gap = pick_gap(tx_throttle);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Random content, with a share of saturated channels.
    task automatic send_random_pixel();
        gcbd_pkg::chan_t ch [4];
        logic            saturate;
        saturate = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < 4; k++)
            ch[k] = saturate ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                             : gcbd_pkg::chan_t'($urandom_range(0, 255));
        send_pixel(ch[0], ch[1], ch[2], ch[3]);
    endtask

    // Sender pause: everything owed must arrive, then a few quiet cycles for
    // pixels still in the line store pipe that close no block.
    task automatic settle();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (tracker.awaited_blocks.size() != 0);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // APB write; junk above bit 10 must be dropped by the block. The bus is then
    // idled so back-to-back writes start from a clean bus.
    task automatic cfg_write(input reg_idx_t idx, input int unsigned value);
        logic [31:0] word;
        word       = $urandom();
        word[10:0] = value[10:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        tracker.write_reg(idx, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [31:0] corner_words [9] = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00,
            32'h0000_00FF, 32'h55AA_55AA, 32'hAA55_AA55, 32'h0180_FE7F
        };
        logic [31:0] box_words [4] = '{
            32'hFF00_FF00, 32'h00FF_FF80, 32'hFFFF_FFFF, 32'h0000_FF40
        };
        int unsigned sent, phase_no, roll;
        int unsigned ratio_eff, ratio_val, width_val, height_val, blk_cols, blk_rows;
        int unsigned frame_px, px_total, break_at;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Ratio 1 under reset width/height: every pixel is its own block, so
        // each channel extreme goes straight through both curves.
        cfg_write(REG_RATIO, 1);
        foreach (corner_words[k])
            send_pixel(corner_words[k][31:24], corner_words[k][23:16],
                       corner_words[k][15:8], corner_words[k][7:0]);

        // Full drain, then a write to the unused slot: no restart expected.
        settle();
        cfg_write(REG_SPARE, $urandom_range(0, 2047));
        repeat (2) send_random_pixel();
        settle();

        // Image smaller than one block: nothing may come out.
        cfg_write(REG_WIDTH, 3);
        cfg_write(REG_HEIGHT, 3);
        cfg_write(REG_RATIO, 4);
        repeat (9) send_random_pixel();
        settle();

        // Zeros clamp to a 1x1 frame at ratio 1; each pixel ends a frame.
        cfg_write(REG_WIDTH, 0);
        cfg_write(REG_HEIGHT, 0);
        cfg_write(REG_RATIO, 0);
        repeat (3) send_random_pixel();
        settle();

        // One 2x2 block of mixed extremes exercises the averaging path.
        cfg_write(REG_WIDTH, 2);
        cfg_write(REG_HEIGHT, 2);
        cfg_write(REG_RATIO, 2);
        foreach (box_words[k])
            send_pixel(box_words[k][31:24], box_words[k][23:16],
                       box_words[k][15:8], box_words[k][7:0]);

        // Random phases: whole frames with random content, sometimes cut
        // short, sometimes interrupted by a spare-slot write mid-frame.
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            rx_throttle <= ($urandom_range(0, 3) != 0);
            tx_throttle = ($urandom_range(0, 3) != 0);
            if (phase_no == 2) begin
                // Oversized width clamps to the full line; single row, ratio 1.
                ratio_val  = $urandom_range(0, 1);
                width_val  = $urandom_range(gcbd_pkg::MAX_WIDTH + 1, 2047);
                height_val = 1;
                px_total   = gcbd_pkg::MAX_WIDTH + $urandom_range(1, 20);
            end else if (phase_no == 4) begin
                // Oversized ratio clamps to the largest block.
                ratio_val  = $urandom_range(gcbd_pkg::MAX_RATIO + 1, 31);
                width_val  = $urandom_range(16, 24);
                height_val = $urandom_range(16, 17);
                px_total   = width_val * height_val + $urandom_range(0, 20);
            end else begin
                roll       = $urandom_range(0, 9);
                ratio_eff  = (roll < 7) ? $urandom_range(1, 4) :
                             (roll < 9) ? $urandom_range(5, 8) : $urandom_range(9, 16);
                ratio_val  = (ratio_eff == 1 && $urandom_range(0, 1)) ? 0 : ratio_eff;
                blk_cols   = (ratio_eff <= 4) ? $urandom_range(1, 6) : $urandom_range(1, 2);
                blk_rows   = (ratio_eff <= 4) ? $urandom_range(1, 4) : 1;
                width_val  = ratio_eff * blk_cols + $urandom_range(0, ratio_eff - 1);
                height_val = ratio_eff * blk_rows
                           + $urandom_range(0, (ratio_eff > 2) ? 2 : ratio_eff - 1);
                frame_px   = width_val * height_val;
                px_total   = frame_px * ((frame_px > 200) ? 1 : $urandom_range(1, 3));
                if ($urandom_range(0, 1))
                    px_total += $urandom_range(1, frame_px);
            end
            cfg_write(REG_RATIO, ratio_val);
            cfg_write(REG_WIDTH, width_val);
            cfg_write(REG_HEIGHT, height_val);
            break_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, px_total) : px_total;
            for (int unsigned k = 0; k < px_total; k++) begin
                if (k == break_at) begin
                    settle();
                    cfg_write(REG_SPARE, $urandom_range(0, 2047));
                end
                send_random_pixel();
            end
            sent += px_total;
            phase_no++;
        end

        settle();
        if (tracker.mismatches == 0 && tracker.awaited_blocks.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
